@@ sv/rtes_pkg.sv @@
// Shared types and constants for the record total exchange sort block.
package rtes_pkg;

	localparam int MAX_RECORDS_DEF = 64;
	localparam int MARK_W = 6;
	localparam int TAG_W = 8;
	localparam int TOTAL_W = 9;

	typedef struct packed {
		logic [MARK_W-1:0] quiz_one;
		logic [MARK_W-1:0] quiz_two;
		logic [MARK_W-1:0] quiz_three;
		logic [MARK_W-1:0] quiz_four;
		logic [MARK_W-1:0] assign_one;
		logic [MARK_W-1:0] assign_two;
		logic [MARK_W-1:0] assign_three;
		logic [MARK_W-1:0] assign_four;
		logic [TAG_W-1:0] record_tag;
		logic final_record;
	} rec_t;

	typedef struct packed {
		logic [TAG_W-1:0] out_tag;
		logic [TOTAL_W-1:0] out_total;
		logic out_last;
	} res_t;

	// One stored record.
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [TOTAL_W-1:0] total;
	} entry_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_I,
		ST_LD_I,
		ST_CMP,
		ST_WR_I,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic wr_load; // write incoming record at waddr
		logic wr_cur;  // write held entry at waddr
		logic ld_cur;  // held entry <= read data
		logic cmp;     // compare held entry with read data, swap if smaller
		logic ld_out;  // result register <= read data
		logic last;    // last flag for the loaded result
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_busy; // result register holds a transaction not taken this cycle
	} sts_t;

endpackage

@@ sv/record_total_exchange_sort.sv @@
// Top level: records in, totals sorted in descending order out.
//
//   channel   handshake               payload  direction
//   rec       rec_valid / rec_ready   rec_t    in   one record per transaction
//   res       res_valid / res_ready   res_t    out  one sorted record per transaction
//
// Records are taken back to back while loading. A final record starts the sort, one
// compare per cycle on the read and write ports of the record memory. Emitting reads
// each result, then loads it into the result register when that register is free.
// Records are taken only while loading; a pending result does not block loading.
// Reset clears control state only; memory contents are never read before written.
module record_total_exchange_sort #(
	parameter int MAX_RECORDS = rtes_pkg::MAX_RECORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rec_valid,
	output logic rec_ready,
	input  rtes_pkg::rec_t rec,
	output logic res_valid,
	input  logic res_ready,
	output rtes_pkg::res_t res
);
	import rtes_pkg::*;

	localparam int AW = $clog2(MAX_RECORDS);

	cmd_t cmd;
	sts_t sts;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;

	rtes_ctrl #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec_final(rec.final_record),
		.rec_ready(rec_ready),
		.sts(sts),
		.cmd(cmd),
		.raddr(raddr),
		.waddr(waddr)
	);

	rtes_datapath #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.rec(rec),
		.cmd(cmd),
		.raddr(raddr),
		.waddr(waddr),
		.sts(sts),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// result register must be empty when a new result is loaded
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> !res_valid)
		else $error("result loaded over a pending transaction");

	a_final_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec_ready && rec.final_record) |=> !rec_ready)
		else $error("input taken right after a final record");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd.ld_out))
		else $error("result valid without a load");

	a_no_write_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> !(cmd.wr_load || cmd.wr_cur || cmd.cmp))
		else $error("memory written while emitting");

endmodule

@@ sv/rtes_datapath.sv @@
// Datapath: record memory, mark adder, held entry for the sort, result register.
module rtes_datapath #(
	parameter int MAX_RECORDS = rtes_pkg::MAX_RECORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  rtes_pkg::rec_t rec,
	input  rtes_pkg::cmd_t cmd,
	input  logic [$clog2(MAX_RECORDS)-1:0] raddr,
	input  logic [$clog2(MAX_RECORDS)-1:0] waddr,
	output rtes_pkg::sts_t sts,
	output logic res_valid,
	input  logic res_ready,
	output rtes_pkg::res_t res
);
	import rtes_pkg::*;

	entry_t mem [MAX_RECORDS];
	entry_t rdata_q;
	entry_t cur_q;
	entry_t rec_entry;
	entry_t wdata;
	logic we;
	logic swap;
	res_t res_q;
	logic res_valid_q;

	always_comb begin
		rec_entry.tag = rec.record_tag;
		rec_entry.total = TOTAL_W'(rec.quiz_one) + TOTAL_W'(rec.quiz_two)
			+ TOTAL_W'(rec.quiz_three) + TOTAL_W'(rec.quiz_four)
			+ TOTAL_W'(rec.assign_one) + TOTAL_W'(rec.assign_two)
			+ TOTAL_W'(rec.assign_three) + TOTAL_W'(rec.assign_four);
	end

	assign swap = cur_q.total < rdata_q.total;
	assign we = cmd.wr_load | cmd.wr_cur | (cmd.cmp & swap);
	assign wdata = cmd.wr_load ? rec_entry : cur_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Held entry i bubbles down: it trades places with every larger total met.
	always_ff @(posedge clk) begin
		if (cmd.ld_cur || (cmd.cmp && swap)) begin
			cur_q <= rdata_q;
		end
		if (cmd.ld_out) begin
			res_q.out_tag <= rdata_q.tag;
			res_q.out_total <= rdata_q.total;
			res_q.out_last <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign sts.out_busy = res_valid_q & ~res_ready;
	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

@@ sv/rtes_ctrl.sv @@
// Controller: load, sort and emit sequencing with record and loop counters.
module rtes_ctrl #(
	parameter int MAX_RECORDS = rtes_pkg::MAX_RECORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rec_valid,
	input  logic rec_final,
	output logic rec_ready,
	input  rtes_pkg::sts_t sts,
	output rtes_pkg::cmd_t cmd,
	output logic [$clog2(MAX_RECORDS)-1:0] raddr,
	output logic [$clog2(MAX_RECORDS)-1:0] waddr
);
	import rtes_pkg::*;

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] j_q, j_d;
	logic [CW-1:0] k_q, k_d;
	logic [CW-1:0] last_idx;
	logic [CW-1:0] i_inc;
	logic [CW-1:0] j_inc;
	logic [CW-1:0] n_new;
	logic room;

	assign last_idx = count_q - CW'(1);
	assign i_inc = i_q + CW'(1);
	assign j_inc = j_q + CW'(1);
	assign room = count_q < CW'(MAX_RECORDS);
	assign n_new = room ? count_q + CW'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			i_q <= i_d;
			j_q <= j_d;
			k_q <= k_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		cmd = '0;
		rec_ready = 1'b0;
		raddr = i_q[AW-1:0];
		waddr = count_q[AW-1:0];
		unique case (state_q)
			ST_LOAD: begin
				rec_ready = 1'b1;
				if (rec_valid) begin
					// record beyond capacity is dropped, but a final flag still counts
					cmd.wr_load = room;
					count_d = n_new;
					if (rec_final) begin
						i_d = '0;
						k_d = '0;
						state_d = (n_new >= CW'(2)) ? ST_RD_I : ST_EMIT_RD;
					end
				end
			end
			ST_RD_I: begin
				raddr = i_q[AW-1:0];
				state_d = ST_LD_I;
			end
			ST_LD_I: begin
				cmd.ld_cur = 1'b1;
				raddr = i_inc[AW-1:0];
				j_d = i_inc;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				waddr = j_q[AW-1:0];
				raddr = j_inc[AW-1:0];
				if (j_q == last_idx) begin
					state_d = ST_WR_I;
				end else begin
					j_d = j_inc;
				end
			end
			ST_WR_I: begin
				cmd.wr_cur = 1'b1;
				waddr = i_q[AW-1:0];
				raddr = i_inc[AW-1:0];
				i_d = i_inc;
				state_d = (i_inc == last_idx) ? ST_EMIT_RD : ST_LD_I;
			end
			ST_EMIT_RD: begin
				raddr = k_q[AW-1:0];
				if (!sts.out_busy) begin
					state_d = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				cmd.ld_out = 1'b1;
				cmd.last = (k_q == last_idx);
				if (k_q == last_idx) begin
					count_d = '0;
					state_d = ST_LOAD;
				end else begin
					k_d = k_q + CW'(1);
					state_d = ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule
